@@ sv/aco_pkg.sv @@
`default_nettype none
package aco_pkg;

  localparam int CMD_W  = 3;
  localparam int LET_W  = 5;
  localparam int NODE_W = 10;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_LET  = 3'd0,
    CMD_INS_END  = 3'd1,
    CMD_FIND_LET = 3'd2,
    CMD_FIND_END = 3'd3,
    CMD_BUILD    = 3'd4,
    CMD_READ     = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_IDX = 2'd2,
    ST_UNBUILT = 2'd3
  } status_t;

endpackage
`default_nettype wire

@@ sv/aco_if.sv @@
`default_nettype none
interface aco_req_if;
  import aco_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [LET_W-1:0]  letter;
  logic [NODE_W-1:0] node;
  modport source (output valid, cmd, letter, node, input ready);
  modport sink   (input valid, cmd, letter, node, output ready);
endinterface

interface aco_rsp_if;
  import aco_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              found;
  logic [NODE_W-1:0] target;
  logic [NODE_W-1:0] link_target;
  modport source (output valid, status, found, target, link_target, input ready);
  modport sink   (input valid, status, found, target, link_target, output ready);
endinterface
`default_nettype wire

@@ sv/aho_corasick_trie_builder_core.sv @@
`default_nettype none
// Channel   Direction  Word contents
// req       in         cmd, letter, node
// rsp       out        status, found, target, link_target
//
// One command word is taken at a time; req.ready is high only while the
// sequencer is idle. Insert end, a find end after a miss, a failing read, a
// letter outside the alphabet or refused by a full table, and the unused
// codes are answered without a table read. Letter steps, good reads and a
// find end after a hit first read a table, and an insert letter that
// allocates a node also clears the new child row. Build scans each queued
// node's children and fills each child's row, falling back through the
// suffix link where a child is missing. After reset the root's child row is
// cleared before the first word is taken. A stalled rsp holds its word; one
// further req word may be taken and worked on meanwhile.
module aho_corasick_trie_builder_core #(
  parameter int MAX_NODES = 1024,
  parameter int ALPHABET  = 26
) (
  input logic clk,
  input logic rst,
  aco_req_if.sink   req,
  aco_rsp_if.source rsp
);
  import aco_pkg::*;

  localparam int NW   = $clog2(MAX_NODES);
  localparam int LW   = $clog2(ALPHABET);
  localparam int CNW  = NW + 1;
  localparam int CAW  = NW + LW;
  localparam int CMPW = (CNW > NODE_W) ? CNW : NODE_W;
  localparam logic [LW-1:0]  LAST_LET = LW'(ALPHABET - 1);
  localparam logic [CNW-1:0] FULL_CNT = CNW'(MAX_NODES);

  // One-hot sequencer. S_* states serve word commands, B_* states the
  // breadth-first build.
  typedef enum logic [22:0] {
    S_INIT  = 23'h000001,
    S_IDLE  = 23'h000002,
    S_CRD   = 23'h000004,
    S_CEV   = 23'h000008,
    S_CLR   = 23'h000010,
    S_TRD   = 23'h000020,
    S_TEV   = 23'h000040,
    S_GRD   = 23'h000080,
    S_GEV   = 23'h000100,
    S_DONE  = 23'h000200,
    B_START = 23'h000400,
    B_CB    = 23'h000800,
    B_CBW   = 23'h001000,
    B_GBI   = 23'h002000,
    B_GBW   = 23'h004000,
    B_HEAD  = 23'h008000,
    B_QW    = 23'h010000,
    B_LZI   = 23'h020000,
    B_LZW   = 23'h040000,
    B_CA    = 23'h080000,
    B_CAW   = 23'h100000,
    B_GLI   = 23'h200000,
    B_GLW   = 23'h400000
  } state_t;

  state_t         state;
  logic [NW-1:0]  cursor;
  logic [CNW-1:0] node_count;
  logic           miss;
  logic           built;
  cmd_t           cmd_r;
  logic [LW-1:0]  let_r;
  logic [NW-1:0]  node_r;
  logic [LW-1:0]  a_r;
  logic [LW-1:0]  b_r;
  logic [CNW-1:0] head;
  logic [CNW-1:0] tail;
  logic [NW-1:0]  z_r;
  logic [NW-1:0]  u_r;
  logic [NW-1:0]  lz_r;
  logic [NW-1:0]  lu_r;
  logic           root_mode;
  status_t        res_status;
  logic           res_found;
  logic [NW-1:0]  res_target;
  logic [NW-1:0]  res_link;
  logic           o_valid;
  status_t        o_status;
  logic           o_found;
  logic [NODE_W-1:0] o_target;
  logic [NODE_W-1:0] o_link;

  // Table ports.
  logic           c_we, t_we, t_wdata, t_rd, l_we, g_we, q_we;
  logic [CAW-1:0] c_waddr, c_raddr, g_waddr, g_raddr;
  logic [NW-1:0]  c_wdata, c_rd, g_wdata, g_rd, l_wdata, l_rd, q_wdata, q_rd;
  logic [NW-1:0]  t_waddr, t_raddr, l_waddr, l_raddr, q_waddr, q_raddr;

  logic          acc;
  cmd_t          cmd_in;
  logic [LW-1:0] let_in;
  logic          letter_ok;
  logic          node_ok;
  logic          alloc;
  logic          b_step;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid & req.ready;
  assign cmd_in    = cmd_t'(req.cmd);
  assign let_in    = LW'(req.letter);
  assign letter_ok = 32'(req.letter) < ALPHABET;
  assign node_ok   = CMPW'(req.node) < CMPW'(node_count);

  // An insert letter step found no child and there is room for a new node.
  assign alloc  = (state == S_CEV) && (cmd_r == CMD_INS_LET) && (c_rd == '0) &&
                  (node_count != FULL_CNT);
  // One transition of the current node has been written this cycle.
  assign b_step = ((state == B_CBW) && ((c_rd != '0) || root_mode)) || (state == B_GBW);

  assign rsp.valid       = o_valid;
  assign rsp.status      = o_status;
  assign rsp.found       = o_found;
  assign rsp.target      = o_target;
  assign rsp.link_target = o_link;

  aco_ram #(.AW(CAW), .DW(NW)) u_child (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rd)
  );
  aco_ram #(.AW(NW), .DW(1)) u_term (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rd)
  );
  aco_ram #(.AW(NW), .DW(NW)) u_link (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rd)
  );
  aco_ram #(.AW(CAW), .DW(NW)) u_goto (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rd)
  );
  aco_ram #(.AW(NW), .DW(NW)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rd)
  );

  // Address and write steering for the tables.
  always_comb begin
    c_we    = 1'b0;
    c_waddr = {cursor, let_r};
    c_wdata = node_count[NW-1:0];
    if (state == S_INIT) begin
      c_we    = 1'b1;
      c_waddr = {NW'(0), b_r};
      c_wdata = '0;
    end else if (state == S_CLR) begin
      c_we    = 1'b1;
      c_waddr = {cursor, b_r};
      c_wdata = '0;
    end else if (alloc) begin
      c_we = 1'b1;
    end
    if (state == B_CB) begin
      c_raddr = {u_r, b_r};
    end else if (state == B_CA) begin
      c_raddr = {z_r, a_r};
    end else begin
      c_raddr = {cursor, let_r};
    end

    t_we    = 1'b0;
    t_waddr = cursor;
    t_wdata = 1'b1;
    if (state == S_INIT) begin
      t_we    = 1'b1;
      t_waddr = '0;
      t_wdata = 1'b0;
    end else if (alloc) begin
      t_we    = 1'b1;
      t_waddr = node_count[NW-1:0];
      t_wdata = 1'b0;
    end else if (acc && (cmd_in == CMD_INS_END) && !miss) begin
      t_we = 1'b1;
    end
    t_raddr = cursor;

    l_we    = 1'b0;
    l_waddr = u_r;
    l_wdata = g_rd;
    if (state == B_START) begin
      l_we    = 1'b1;
      l_waddr = '0;
      l_wdata = '0;
    end else if ((state == B_CAW) && (c_rd != '0) && (z_r == '0)) begin
      l_we    = 1'b1;
      l_waddr = c_rd;
      l_wdata = '0;
    end else if (state == B_GLW) begin
      l_we = 1'b1;
    end
    l_raddr = (state == S_GRD) ? node_r : z_r;

    g_we    = 1'b0;
    g_waddr = {u_r, b_r};
    g_wdata = g_rd;
    if ((state == B_CBW) && ((c_rd != '0) || root_mode)) begin
      g_we    = 1'b1;
      g_wdata = c_rd;
    end else if (state == B_GBW) begin
      g_we = 1'b1;
    end
    if (state == S_GRD) begin
      g_raddr = {node_r, let_r};
    end else if (state == B_GLI) begin
      g_raddr = {lz_r, a_r};
    end else begin
      g_raddr = {lu_r, b_r};
    end

    q_we    = 1'b0;
    q_waddr = tail[NW-1:0];
    q_wdata = u_r;
    if (state == B_START) begin
      q_we    = 1'b1;
      q_waddr = '0;
      q_wdata = '0;
    end else if (b_step && (b_r == LAST_LET) && !root_mode) begin
      q_we = 1'b1;
    end
    q_raddr = head[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      b_r        <= '0;
      cursor     <= '0;
      node_count <= CNW'(1);
      miss       <= 1'b0;
      built      <= 1'b0;
      root_mode  <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      // A finished word is loaded when the output register is free or is
      // being taken this cycle.
      if ((state == S_DONE) && (!o_valid || rsp.ready)) begin
        o_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (b_r == LAST_LET) begin
            state <= S_IDLE;
          end else begin
            b_r <= b_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (acc) begin
            cmd_r      <= cmd_in;
            let_r      <= let_in;
            node_r     <= NW'(req.node);
            res_status <= ST_OK;
            res_found  <= 1'b0;
            res_target <= '0;
            res_link   <= '0;
            state      <= S_DONE;
            case (cmd_in)
              CMD_INS_LET: begin
                built      <= 1'b0;
                res_target <= cursor;
                if (miss) begin
                  res_status <= ST_FULL;
                end else if (letter_ok) begin
                  state <= S_CRD;
                end
              end
              CMD_INS_END: begin
                built <= 1'b0;
                if (miss) begin
                  res_status <= ST_FULL;
                end
                cursor <= '0;
                miss   <= 1'b0;
              end
              CMD_FIND_LET: begin
                res_target <= cursor;
                if (!miss) begin
                  if (letter_ok) begin
                    state <= S_CRD;
                  end else begin
                    miss <= 1'b1;
                  end
                end
              end
              CMD_FIND_END: begin
                if (miss) begin
                  cursor <= '0;
                  miss   <= 1'b0;
                end else begin
                  state <= S_TRD;
                end
              end
              CMD_BUILD: begin
                state <= B_START;
              end
              CMD_READ: begin
                if (!node_ok || !letter_ok) begin
                  res_status <= ST_BAD_IDX;
                end else if (!built) begin
                  res_status <= ST_UNBUILT;
                end else begin
                  state <= S_GRD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CRD: begin
          state <= S_CEV;
        end
        S_CEV: begin
          state <= S_DONE;
          if (c_rd != '0) begin
            cursor     <= c_rd;
            res_target <= c_rd;
          end else if (cmd_r == CMD_INS_LET) begin
            if (alloc) begin
              // New node: its child row is cleared before the word completes.
              cursor     <= node_count[NW-1:0];
              node_count <= node_count + 1'b1;
              b_r        <= '0;
              state      <= S_CLR;
            end else begin
              res_status <= ST_FULL;
              miss       <= 1'b1;
            end
          end else begin
            miss <= 1'b1;
          end
        end
        S_CLR: begin
          if (b_r == LAST_LET) begin
            res_target <= cursor;
            state      <= S_DONE;
          end else begin
            b_r <= b_r + 1'b1;
          end
        end
        S_TRD: begin
          state <= S_TEV;
        end
        S_TEV: begin
          res_found <= t_rd;
          cursor    <= '0;
          miss      <= 1'b0;
          state     <= S_DONE;
        end
        S_GRD: begin
          state <= S_GEV;
        end
        S_GEV: begin
          res_target <= g_rd;
          res_link   <= l_rd;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!o_valid || rsp.ready) begin
            o_status <= res_status;
            o_found  <= res_found;
            o_target <= NODE_W'(res_target);
            o_link   <= NODE_W'(res_link);
            state    <= S_IDLE;
          end
        end
        B_START: begin
          // The root's row is copied from its children as they stand.
          head      <= '0;
          tail      <= CNW'(1);
          u_r       <= '0;
          lu_r      <= '0;
          b_r       <= '0;
          root_mode <= 1'b1;
          state     <= B_CB;
        end
        B_CB: begin
          state <= B_CBW;
        end
        B_CBW, B_GBW: begin
          if ((state == B_CBW) && (c_rd == '0) && !root_mode) begin
            state <= B_GBI;
          end else if (b_r == LAST_LET) begin
            if (root_mode) begin
              root_mode <= 1'b0;
              state     <= B_HEAD;
            end else begin
              tail <= tail + 1'b1;
              if (a_r == LAST_LET) begin
                state <= B_HEAD;
              end else begin
                a_r   <= a_r + 1'b1;
                state <= B_CA;
              end
            end
          end else begin
            b_r   <= b_r + 1'b1;
            state <= B_CB;
          end
        end
        B_GBI: begin
          state <= B_GBW;
        end
        B_HEAD: begin
          if (head == tail) begin
            built <= 1'b1;
            state <= S_DONE;
          end else begin
            head  <= head + 1'b1;
            state <= B_QW;
          end
        end
        B_QW: begin
          z_r   <= q_rd;
          state <= B_LZI;
        end
        B_LZI: begin
          state <= B_LZW;
        end
        B_LZW: begin
          lz_r  <= l_rd;
          a_r   <= '0;
          state <= B_CA;
        end
        B_CA: begin
          state <= B_CAW;
        end
        B_CAW: begin
          if (c_rd == '0) begin
            if (a_r == LAST_LET) begin
              state <= B_HEAD;
            end else begin
              a_r   <= a_r + 1'b1;
              state <= B_CA;
            end
          end else begin
            u_r <= c_rd;
            b_r <= '0;
            if (z_r != '0) begin
              state <= B_GLI;
            end else begin
              lu_r  <= '0;
              state <= B_CB;
            end
          end
        end
        B_GLI: begin
          state <= B_GLW;
        end
        B_GLW: begin
          lu_r  <= g_rd;
          state <= B_CB;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/aco_ram.sv @@
`default_nettype none
// Simple dual-port RAM: one write port, one read port with registered data.
module aco_ram #(
  parameter int AW = 10,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/aco_chk.sv @@
`default_nettype none
module aco_chk (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_status,
  input logic       rsp_found,
  input logic [9:0] rsp_target,
  input logic [9:0] rsp_link
);
  import aco_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found) &&
      $stable(rsp_target) && $stable(rsp_link))
    else $error("rsp word changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req taken twice in a row");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> rsp_status == ST_OK)
    else $error("found set with a failing status");

  a_link_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_link != '0) |-> rsp_status == ST_OK && !rsp_found)
    else $error("link reported outside a good read");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp valid right after reset");
endmodule

bind aho_corasick_trie_builder_core aco_chk u_aco_chk (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_found(rsp.found),
  .rsp_target(rsp.target), .rsp_link(rsp.link_target)
);
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
  import aco_pkg::*;

  localparam int MAX_NODES = 1024;
  localparam int ALPHABET  = 26;
  // Cycles with no word moving on either channel before the run is abandoned.
  // The longest quiet stretch is a build over a full node table.
  localparam int IDLE_LIMIT = 1000000;
  // Settling time at the end of each test, after every answer is in.
  localparam int TAIL_CYCLES = 64;
  // Length of the forced hold-off on the answer channel.
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [NODE_W-1:0] target;
    logic [NODE_W-1:0] link_target;
  } answer_t;

  logic clk;
  logic rst;

  aco_req_if req_ch ();
  aco_rsp_if rsp_ch ();

  aho_corasick_trie_builder_core #(
    .MAX_NODES(MAX_NODES),
    .ALPHABET (ALPHABET)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the trie and the automaton, updated in the order in which
  // command words are accepted.
  logic [NODE_W-1:0] trie_child [MAX_NODES][ALPHABET];
  logic              trie_term  [MAX_NODES];
  logic [NODE_W-1:0] trie_link  [MAX_NODES];
  logic [NODE_W-1:0] trie_go    [MAX_NODES][ALPHABET];
  int                trie_nodes;
  logic [NODE_W-1:0] trie_cursor;
  logic              trie_miss;
  logic              trie_built;

  // Predicted answers in order of acceptance; the checker walks it by index.
  answer_t pending_answers [$];

  int  errors = 0;
  int  words_sent;
  int  answers_checked = 0;
  int  builds_sent;
  int  idle_count = 0;
  int  rsp_hold = 0;
  int  hold_asks;
  int  hold_seen = 0;
  bit  no_gaps;
  bit  req_fire;
  bit  rsp_fire;
  answer_t rsp_seen;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The breadth-first pass: suffix links come from the parent's link, and a
  // missing child falls back to the transition of the suffix link.
  task automatic run_build();
    int order [MAX_NODES];
    int rd_pos;
    int wr_pos;
    int parent;
    int kid;
    trie_link[0] = '0;
    for (int a = 0; a < ALPHABET; a++) trie_go[0][a] = trie_child[0][a];
    order[0] = 0;
    rd_pos = 0;
    wr_pos = 1;
    while (rd_pos < wr_pos) begin
      parent = order[rd_pos];
      rd_pos++;
      for (int a = 0; a < ALPHABET; a++) begin
        kid = int'(trie_child[parent][a]);
        if (kid != 0) begin
          trie_link[kid] = (parent != 0) ? trie_go[trie_link[parent]][a] : '0;
          for (int b = 0; b < ALPHABET; b++)
            trie_go[kid][b] = (trie_child[kid][b] != 0) ? trie_child[kid][b]
                                                        : trie_go[trie_link[kid]][b];
          if (wr_pos < MAX_NODES) begin
            order[wr_pos] = kid;
            wr_pos++;
          end
        end
      end
    end
    trie_built = 1'b1;
  endtask

  // Applies one accepted command word to the shadow state and returns the
  // answer the block must give for it.
  task automatic predict_answer(input logic [CMD_W-1:0] c, input logic [LET_W-1:0] l,
                                input logic [NODE_W-1:0] n, output answer_t ans);
    int kid;
    ans = '0;
    case (c)
      CMD_INS_LET: begin
        trie_built = 1'b0;
        if (trie_miss) begin
          ans.status = ST_FULL;
        end else if (l < ALPHABET) begin
          kid = int'(trie_child[trie_cursor][l]);
          if (kid == 0) begin
            if (trie_nodes >= MAX_NODES) begin
              // Table full: the rest of this word is refused.
              ans.status = ST_FULL;
              trie_miss = 1'b1;
            end else begin
              kid = trie_nodes;
              trie_nodes++;
              trie_child[trie_cursor][l] = NODE_W'(kid);
              trie_cursor = NODE_W'(kid);
            end
          end else begin
            trie_cursor = NODE_W'(kid);
          end
        end
        ans.target = trie_cursor;
      end
      CMD_INS_END: begin
        trie_built = 1'b0;
        if (trie_miss) ans.status = ST_FULL;
        else trie_term[trie_cursor] = 1'b1;
        trie_cursor = '0;
        trie_miss = 1'b0;
      end
      CMD_FIND_LET: begin
        if (!trie_miss) begin
          kid = (l < ALPHABET) ? int'(trie_child[trie_cursor][l]) : 0;
          if (kid == 0) trie_miss = 1'b1;
          else trie_cursor = NODE_W'(kid);
        end
        ans.target = trie_cursor;
      end
      CMD_FIND_END: begin
        ans.found = !trie_miss && trie_term[trie_cursor];
        trie_cursor = '0;
        trie_miss = 1'b0;
      end
      CMD_BUILD: begin
        run_build();
      end
      CMD_READ: begin
        if (n >= trie_nodes || l >= ALPHABET) begin
          ans.status = ST_BAD_IDX;
        end else if (!trie_built) begin
          ans.status = ST_UNBUILT;
        end else begin
          ans.target = trie_go[n][l];
          ans.link_target = trie_link[n];
        end
      end
      default: begin
        // The two unused codes leave everything alone and answer zero.
      end
    endcase
  endtask

  // Handshakes are sampled at the falling edge; valid and ready only move at
  // the rising edge, so the sampled values are the ones seen by the next edge.
  always @(negedge clk) begin
    req_fire = req_ch.valid && req_ch.ready;
    rsp_fire = rsp_ch.valid && rsp_ch.ready;
    rsp_seen.status = rsp_ch.status;
    rsp_seen.found = rsp_ch.found;
    rsp_seen.target = rsp_ch.target;
    rsp_seen.link_target = rsp_ch.link_target;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Response side: compares every accepted answer word with the next
  // prediction and throttles ready, including long forced hold-offs.
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_fire) begin
        if (answers_checked >= pending_answers.size()) begin
          $error("answer word with no command waiting: status %0d target %0d",
                 rsp_seen.status, rsp_seen.target);
          errors++;
        end else begin
          want = pending_answers[answers_checked];
          answers_checked++;
          if (want.status != rsp_seen.status) begin
            $error("status expected %0d got %0d", want.status, rsp_seen.status);
            errors++;
          end
          if (want.found != rsp_seen.found) begin
            $error("found expected %0d got %0d", want.found, rsp_seen.found);
            errors++;
          end
          if (want.target != rsp_seen.target) begin
            $error("target expected %0d got %0d", want.target, rsp_seen.target);
            errors++;
          end
          if (want.link_target != rsp_seen.link_target) begin
            $error("link_target expected %0d got %0d", want.link_target,
                   rsp_seen.link_target);
            errors++;
          end
        end
      end
      if (hold_asks != hold_seen) begin
        hold_seen <= hold_asks;
        rsp_hold <= LONG_HOLD;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
        rsp_hold <= rsp_hold - 1;
        rsp_ch.ready <= 1'b0;
      end else if (no_gaps) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 9) < 7);
        if ($urandom_range(0, 199) == 0) rsp_hold <= $urandom_range(10, 40);
      end
    end
  end

  // Watchdog: any quiet stretch far beyond the slowest build ends the run.
  always @(posedge clk) begin
    if (req_fire || rsp_fire || rst) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("timeout after %0d quiet cycles", idle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offers one command word, waits for it to be taken, then records the
  // predicted answer. Valid stays high when the next word follows at once.
  task automatic send_word(input logic [CMD_W-1:0] c, input logic [LET_W-1:0] l,
                           input logic [NODE_W-1:0] n);
    int gap;
    answer_t ans;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c;
    req_ch.letter <= l;
    req_ch.node <= n;
    do @(posedge clk); while (!req_fire);
    predict_answer(c, l, n, ans);
    pending_answers = {pending_answers, ans};
    words_sent++;
    if (c == CMD_BUILD) builds_sent++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (answers_checked != words_sent);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Sends a whole word, letters then its end command.
  task automatic send_string(input bit is_find, input logic [LET_W-1:0] s [$]);
    foreach (s[i])
      send_word(is_find ? CMD_FIND_LET : CMD_INS_LET, s[i], NODE_W'($urandom));
    send_word(is_find ? CMD_FIND_END : CMD_INS_END, LET_W'($urandom), NODE_W'($urandom));
  endtask

  function automatic void random_string(ref logic [LET_W-1:0] s [$], input int len,
                                        input int top);
    s.delete();
    for (int i = 0; i < len; i++) s = {s, LET_W'($urandom_range(0, top))};
  endfunction

  // Small dictionary with shared prefixes and suffixes, reads before and
  // after the build, out-of-range letters and nodes, and the unused codes.
  task automatic test_directed();
    logic [LET_W-1:0] s [$];
    send_word(CMD_READ, 0, 0);                 // not built yet
    s = '{7, 4};          send_string(0, s);   // "he"
    s = '{18, 7, 4};      send_string(0, s);   // "she"
    s = '{7, 8, 18};      send_string(0, s);   // "his"
    send_word(CMD_INS_LET, 31, 0);             // letter beyond the alphabet
    send_word(CMD_INS_END, 0, 0);              // marks the root
    s = '{18, 7, 4};      send_string(1, s);   // present
    s = '{18, 7};         send_string(1, s);   // prefix only
    s = '{25, 7};         send_string(1, s);   // missing child, then ignored
    send_word(CMD_FIND_LET, 26, 0);
    send_word(CMD_FIND_END, 0, 0);
    send_word(3'd6, 31, 10'h3ff);
    send_word(3'd7, 0, 0);
    send_word(CMD_BUILD, 0, 0);
    send_word(CMD_READ, 4, 5);
    send_word(CMD_READ, 7, 2);
    send_word(CMD_READ, 25, 0);
    send_word(CMD_READ, 26, 1);                // bad letter
    send_word(CMD_READ, 0, 10'h3ff);           // bad node
    send_word(CMD_INS_LET, 0, 0);              // clears the built mark mid-word
    send_word(CMD_READ, 1, 1);
    send_word(CMD_INS_END, 0, 0);
    drain();
  endtask

  // The answer channel stalls for a long stretch while commands keep coming,
  // so the block fills and holds off its command channel.
  task automatic test_backpressure();
    logic [LET_W-1:0] s [$];
    hold_asks++;
    for (int i = 0; i < 4; i++) begin
      random_string(s, $urandom_range(1, 4), 2);
      send_string($urandom_range(0, 1), s);
    end
    drain();
  endtask

  // Mostly whole words over a three-letter alphabet so that lookups often
  // hit, with occasional builds, read bursts, stray commands and mid-word
  // builds mixed in.
  task automatic test_random(input int count);
    logic [LET_W-1:0] s [$];
    int op;
    int start;
    start = words_sent;
    while (words_sent - start < count) begin
      if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
      op = $urandom_range(0, 99);
      if (op < 38) begin
        random_string(s, $urandom_range(1, 4), 2);
        if ($urandom_range(0, 19) == 0) s[0] = LET_W'($urandom_range(0, 31));
        send_string(0, s);
      end else if (op < 70) begin
        random_string(s, $urandom_range(0, 4), ($urandom_range(0, 9) == 0) ? 31 : 2);
        send_string(1, s);
      end else if (op < 74) begin
        send_word(CMD_BUILD, LET_W'($urandom), NODE_W'($urandom));
      end else if (op < 90) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0)
            send_word(CMD_READ, LET_W'($urandom), NODE_W'($urandom));
          else
            send_word(CMD_READ, LET_W'($urandom_range(0, 25)),
                      NODE_W'($urandom_range(0, trie_nodes - 1)));
        end
      end else if (op < 94) begin
        send_word(CMD_W'($urandom_range(6, 7)), LET_W'($urandom), NODE_W'($urandom));
      end else if (op < 97) begin
        // A build in the middle of a search leaves the cursor in place.
        send_word(CMD_FIND_LET, LET_W'($urandom_range(0, 2)), NODE_W'($urandom));
        send_word(CMD_BUILD, 0, 0);
        send_word(CMD_FIND_LET, LET_W'($urandom_range(0, 2)), NODE_W'($urandom));
        send_word(CMD_FIND_END, 0, 0);
      end else begin
        send_word($urandom_range(0, 1) ? CMD_INS_END : CMD_FIND_END, LET_W'($urandom),
                  NODE_W'($urandom));
      end
    end
    no_gaps = 1'b0;
    drain();
  endtask

  // Long words over the whole alphabet until the node table overflows, then
  // one build over the full table and reads spread across it.
  task automatic test_full_table();
    logic [LET_W-1:0] s [$];
    while (trie_nodes < MAX_NODES) begin
      random_string(s, 10, 25);
      send_string(0, s);
    end
    repeat (3) begin
      random_string(s, 6, 25);
      send_string(0, s);
    end
    send_word(CMD_BUILD, 0, 0);
    for (int i = 0; i < 60; i++)
      send_word(CMD_READ, LET_W'($urandom_range(0, 25)),
                (i == 0) ? 10'h3ff : NODE_W'($urandom));
    for (int i = 0; i < 10; i++) begin
      random_string(s, $urandom_range(1, 3), 25);
      send_string(1, s);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = '0;
    req_ch.letter = '0;
    req_ch.node = '0;
    words_sent = 0;
    builds_sent = 0;
    hold_asks = 0;
    no_gaps = 1'b0;
    trie_nodes = 1;
    trie_cursor = '0;
    trie_miss = 1'b0;
    trie_built = 1'b0;
    for (int i = 0; i < MAX_NODES; i++) begin
      trie_term[i] = 1'b0;
      trie_link[i] = '0;
      for (int a = 0; a < ALPHABET; a++) begin
        trie_child[i][a] = '0;
        trie_go[i][a] = '0;
      end
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_random(300);
    test_full_table();

    $display("Sent %0d command words including %0d builds; %0d answers checked.",
             words_sent, builds_sent, answers_checked);
    $display("Trie grew to %0d nodes and overflowed the node table.", trie_nodes);
    if (errors == 0 && answers_checked == words_sent) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
